[hdl/mlc_pkg.sv]
// Package for the motion light controller: transaction types, codes and
// timing constants shared by the configuration block, the core and the top.
// No dependencies.
package mlc_pkg;

  // Time and configuration widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PhotoW  = 10;
  localparam int unsigned LightW  = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  // Smoothed brightness, unsigned 10.8 fixed point
  localparam int unsigned SmoothW   = 18;
  localparam int unsigned SmoothSumW = 21;
  // ceil(2^23 / 5): exact divide by five for sums below 2^22
  localparam int unsigned DivFiveShift = 23;
  localparam logic [SmoothSumW-1:0] DivFiveMul = 21'd1677722;
  // ceil(2^11 / 3): exact divide by three for 10-bit values
  localparam int unsigned DivThreeShift = 11;
  localparam logic [PhotoW-1:0] DivThreeMul = 10'd683;

  localparam int unsigned DetW = 4;
  localparam int unsigned DisCntW = 2;

  localparam logic [TimeW-1:0]   QuietMs        = 32'd5000;
  localparam logic [TimeW-1:0]   HourMs         = 32'd3600000;
  localparam logic [TimeW-1:0]   SixHoursMs     = 32'd21600000;
  localparam logic [TimeW-1:0]   DayMs          = 32'd86400000;
  localparam logic [TimeW-1:0]   TimeoutReset   = 32'd35000;
  localparam logic [PhotoW-1:0]  MaxBrightReset = 10'd100;
  localparam logic [SmoothW-1:0] SmoothReset    = 18'd6400;
  localparam logic [DetW-1:0]    DetWrap        = 4'd9;
  localparam logic [DisCntW-1:0] DisCntMax      = 2'd3;

  typedef enum logic {
    KIND_POLL   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT    = 1'b0,
    CFG_MAX_BRIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_IDLE     = 3'd0,
    ST_MOTION   = 3'd1,
    ST_DIS_1H   = 3'd2,
    ST_DIS_6H   = 3'd3,
    ST_DIS_24H  = 3'd4
  } status_e;

  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 2'd0,
    CMD_ON_50  = 2'd1,
    CMD_ON_100 = 2'd2,
    CMD_OFF    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic              kind;
    logic [TimeW-1:0]  now_ms;
    logic              motion;
    logic [PhotoW-1:0] photo_sample;
    logic [LightW-1:0] reported_light;
    logic              by_controller;
  } mlc_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CmdW-1:0]    light_command;
  } mlc_out_t;

  // Configuration as seen by the core
  typedef struct packed {
    logic [TimeW-1:0]   timeout_default;
    logic [SmoothW-1:0] on_thresh;    // max_brightness in 10.8
    logic [SmoothW-1:0] half_thresh;  // (max_brightness / 3) in 10.8
    logic               timeout_load; // timeout register written this cycle
  } mlc_cfg_t;

  // Disable period for a given escalation count
  function automatic logic [TimeW-1:0] dis_length(input logic [DisCntW-1:0] cnt);
    logic [TimeW-1:0] len;
    unique case (cnt)
      2'd0:    len = '0;
      2'd1:    len = HourMs;
      2'd2:    len = SixHoursMs;
      default: len = DayMs;
    endcase
    return len;
  endfunction

endpackage

[hdl/motion_light_controller.sv]
// Motion light controller top level: input register, decision core, result register.
// Depends on mlc_pkg, mlc_cfg and mlc_core.
//
// Every input transaction (poll or light-state report) yields exactly one result
// transaction. The block accepts one transaction per clock while in_stall_o is low.
// On its way to the output the transaction first sits in the input register, where
// the core evaluates it against the current state and updates that state, and its
// result then loads into the result register, from which it leaves. The core's
// critical path is the brightness smoothing (an add and a 21x21 reciprocal multiply)
// followed by a threshold compare. Input stall rises only when a result is held by a
// stalled output and the input register is occupied. Configuration writes are
// always ready and should be issued only while no transaction is in flight.
module motion_light_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mlc_pkg::mlc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mlc_pkg::mlc_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mlc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mlc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mlc_pkg::*;

  logic      in_valid_q;
  mlc_in_t   in_data_q;
  logic      out_valid_q;
  mlc_out_t  out_data_q;
  logic      advance;
  logic      in_take;
  mlc_cfg_t  cfg;
  mlc_out_t  res;

  // Item in the input register moves on when the result register frees up
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  mlc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mlc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/mlc_cfg.sv]
// Configuration registers of the motion light controller, with the brightness
// thresholds precomputed at write time. Depends on mlc_pkg.
module mlc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mlc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mlc_pkg::CfgDataW-1:0]      cfg_data_i,
  output mlc_pkg::mlc_cfg_t                 cfg_o
);
  import mlc_pkg::*;

  logic [TimeW-1:0]    timeout_q, timeout_d;
  logic [PhotoW-1:0]   max_q, max_d;
  logic [PhotoW-2:0]   third_q, third_d;
  logic [2*PhotoW-1:0] third_prod;
  logic                wr;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i & cfg_ready_o;

  // Divide new max_brightness by three via reciprocal multiply
  assign third_prod = cfg_data_i[PhotoW-1:0] * DivThreeMul;

  always_comb begin
    timeout_d = timeout_q;
    max_d     = max_q;
    third_d   = third_q;
    if (wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT: begin
          timeout_d = cfg_data_i[TimeW-1:0];
        end
        CFG_MAX_BRIGHT: begin
          max_d   = cfg_data_i[PhotoW-1:0];
          third_d = third_prod[DivThreeShift +: PhotoW-1];
        end
        default: begin
          timeout_d = timeout_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      max_q     <= MaxBrightReset;
      third_q   <= (PhotoW-1)'(MaxBrightReset / 3);
    end else begin
      timeout_q <= timeout_d;
      max_q     <= max_d;
      third_q   <= third_d;
    end
  end

  // New timeout is visible in its write cycle so the core reloads that value
  assign cfg_o.timeout_default = timeout_d;
  assign cfg_o.on_thresh       = {max_q, 8'd0};
  assign cfg_o.half_thresh     = {1'b0, third_q, 8'd0};
  assign cfg_o.timeout_load    = wr && (cfg_idx_e'(cfg_index_i) == CFG_TIMEOUT);

endmodule

[hdl/mlc_core.sv]
// Controller state and the per-transaction decision logic: polls, reports,
// disable escalation, brightness smoothing and the off timeout. Depends on mlc_pkg.
module mlc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mlc_pkg::mlc_in_t    item_i,
  input  mlc_pkg::mlc_cfg_t   cfg_i,
  output mlc_pkg::mlc_out_t   res_o
);
  import mlc_pkg::*;

  logic [LightW-1:0]  light_q, light_d;
  logic [DisCntW-1:0] dis_cnt_q, dis_cnt_d;
  logic [DetW-1:0]    det_q, det_d;
  logic               past_q, past_d;
  logic [TimeW-1:0]   st_dis_q, st_dis_d;
  logic [TimeW-1:0]   st_moff_q, st_moff_d;
  logic [TimeW-1:0]   st_motion_q, st_motion_d;
  logic [TimeW-1:0]   st_act_q, st_act_d;
  logic [TimeW-1:0]   timeout_q, timeout_d;
  logic [SmoothW-1:0] smooth_q, smooth_d;

  logic [TimeW-1:0]      now;
  logic [TimeW-1:0]      since_dis, since_moff, since_act, since_motion;
  logic [SmoothSumW-1:0] smooth_sum;
  logic [2*SmoothSumW-1:0] smooth_prod;
  logic [SmoothW-1:0]    smooth_new;
  logic [DetW-1:0]       det_inc;

  assign now          = item_i.now_ms;
  assign since_dis    = now - st_dis_q;
  assign since_moff   = now - st_moff_q;
  assign since_act    = now - st_act_q;
  assign since_motion = now - st_motion_q;
  assign det_inc      = (det_q == DetWrap) ? '0 : det_q + 1'b1;

  // s = (4s + 256p) / 5 with a reciprocal multiply
  assign smooth_sum  = {1'b0, smooth_q, 2'b00} + {3'b000, item_i.photo_sample, 8'd0};
  assign smooth_prod = smooth_sum * DivFiveMul;
  assign smooth_new  = smooth_prod[DivFiveShift +: SmoothW];

  // Next state and result for the transaction in the input register
  always_comb begin
    light_d     = light_q;
    dis_cnt_d   = dis_cnt_q;
    det_d       = det_q;
    past_d      = past_q;
    st_dis_d    = st_dis_q;
    st_moff_d   = st_moff_q;
    st_motion_d = st_motion_q;
    st_act_d    = st_act_q;
    timeout_d   = timeout_q;
    smooth_d    = smooth_q;
    res_o.status        = ST_IDLE;
    res_o.light_command = CMD_NONE;

    if (step_i) begin
      if (item_i.kind == KIND_REPORT) begin
        if (light_q != item_i.reported_light) begin
          if (item_i.by_controller) begin
            if (item_i.reported_light == '0) begin
              if (since_moff < QuietMs) begin
                // Repeated manual off: escalate the disable period
                if (dis_cnt_q != DisCntMax) begin
                  dis_cnt_d = dis_cnt_q + 1'b1;
                end
                st_dis_d = now;
              end else if (st_dis_q != '0) begin
                st_dis_d  = '0;
                dis_cnt_d = '0;
              end
              timeout_d = cfg_i.timeout_default;
              st_moff_d = now;
            end else begin
              timeout_d = HourMs;
            end
            st_act_d = now;
          end
          light_d = item_i.reported_light;
        end
      end else if (since_dis < dis_length(dis_cnt_q)) begin
        // Detection disabled: report graded status only
        unique case (dis_cnt_q)
          2'd3:    res_o.status = ST_DIS_24H;
          2'd2:    res_o.status = ST_DIS_6H;
          default: res_o.status = ST_DIS_1H;
        endcase
      end else if (since_act < QuietMs) begin
        // Quiet period after a manual action
        res_o.status = ST_IDLE;
      end else if (item_i.motion) begin
        det_d       = det_inc;
        past_d      = 1'b1;
        st_motion_d = now;
        if (light_q == '0 && past_q) begin
          smooth_d = smooth_new;
          if (smooth_new <= cfg_i.on_thresh) begin
            res_o.light_command = (smooth_new < cfg_i.half_thresh) ? CMD_ON_50 : CMD_ON_100;
          end
        end
        if (det_inc == DetW'(1)) begin
          res_o.status = ST_MOTION;
        end
      end else begin
        det_d  = '0;
        past_d = 1'b0;
        if (light_q != '0 && st_motion_q != '0 && since_motion > timeout_q) begin
          res_o.light_command = CMD_OFF;
          timeout_d = cfg_i.timeout_default;
        end
      end
    end

    // Timeout register write also reloads the active timeout
    if (cfg_i.timeout_load) begin
      timeout_d = cfg_i.timeout_default;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q     <= '0;
      dis_cnt_q   <= '0;
      det_q       <= '0;
      past_q      <= 1'b0;
      st_dis_q    <= '0;
      st_moff_q   <= '0;
      st_motion_q <= '0;
      st_act_q    <= '0;
      timeout_q   <= TimeoutReset;
      smooth_q    <= SmoothReset;
    end else begin
      light_q     <= light_d;
      dis_cnt_q   <= dis_cnt_d;
      det_q       <= det_d;
      past_q      <= past_d;
      st_dis_q    <= st_dis_d;
      st_moff_q   <= st_moff_d;
      st_motion_q <= st_motion_d;
      st_act_q    <= st_act_d;
      timeout_q   <= timeout_d;
      smooth_q    <= smooth_d;
    end
  end

endmodule

[bench/mlc_checker.sv]
// Checker for the motion light controller: watches the input, result and
// register write channels, predicts every result and compares it field by field.
// Depends on mlc_pkg.
module mlc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  mlc_pkg::mlc_in_t             in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  mlc_pkg::mlc_out_t            out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [mlc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mlc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           actions_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlc_pkg::*;

  localparam logic [LightW-1:0] LightOff  = 2'd0;
  localparam int unsigned       PrintCap  = 200;

  // Register copies
  logic [TimeW-1:0]   timeout_dflt;
  logic [PhotoW-1:0]  bright_limit;

  // Controller state
  logic [LightW-1:0]  light_state;
  logic [DisCntW-1:0] dis_cnt;
  logic [DetW-1:0]    det_cnt;
  logic               det_seen;
  logic [TimeW-1:0]   t_disabled;
  logic [TimeW-1:0]   t_manual_off;
  logic [TimeW-1:0]   t_motion;
  logic [TimeW-1:0]   t_manual;
  logic [TimeW-1:0]   dis_len;
  logic [TimeW-1:0]   cur_timeout;
  logic [SmoothW-1:0] smooth;

  mlc_out_t pending_results[$];
  int       error_total;
  int       checked_total;
  int       action_total;

  task automatic report_mismatch(input string msg);
    error_total++;
    if (error_total <= PrintCap) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic clear_state();
    timeout_dflt = TimeoutReset;
    bright_limit = MaxBrightReset;
    light_state  = LightOff;
    dis_cnt      = '0;
    det_cnt      = '0;
    det_seen     = 1'b0;
    t_disabled   = '0;
    t_manual_off = '0;
    t_motion     = '0;
    t_manual     = '0;
    dis_len      = '0;
    cur_timeout  = TimeoutReset;
    smooth       = SmoothReset;
  endtask

  // Light-state report: manual offs in quick succession escalate the disable period
  function automatic void note_light_report(input mlc_in_t t);
    logic [TimeW-1:0] since_off;
    since_off = t.now_ms - t_manual_off;
    if (light_state == t.reported_light) return;
    if (t.by_controller) begin
      if (t.reported_light == LightOff) begin
        if (since_off < QuietMs) begin
          if (dis_cnt < DisCntMax) dis_cnt = dis_cnt + 2'd1;
          case (dis_cnt)
            2'd1:    dis_len = HourMs;
            2'd2:    dis_len = SixHoursMs;
            default: dis_len = DayMs;
          endcase
          t_disabled = t.now_ms;
        end else if (t_disabled != '0) begin
          t_disabled = '0;
          dis_cnt    = '0;
          dis_len    = '0;
        end
        cur_timeout  = timeout_dflt;
        t_manual_off = t.now_ms;
      end else begin
        cur_timeout = HourMs;
      end
      t_manual = t.now_ms;
    end
    light_state = t.reported_light;
  endfunction

  // Poll: disabled status, quiet period, motion counting, smoothing and on/off
  function automatic mlc_out_t evaluate_poll(input mlc_in_t t);
    mlc_out_t         r;
    logic [TimeW-1:0] since_dis;
    logic [TimeW-1:0] since_manual;
    logic [31:0]      mixed;
    logic [31:0]      on_lim;
    logic [31:0]      half_lim;
    logic             was_seen;
    r.status        = ST_IDLE;
    r.light_command = CMD_NONE;
    since_dis    = t.now_ms - t_disabled;
    since_manual = t.now_ms - t_manual;
    if (since_dis < dis_len) begin
      if (dis_len > SixHoursMs)  r.status = ST_DIS_24H;
      else if (dis_len > HourMs) r.status = ST_DIS_6H;
      else                       r.status = ST_DIS_1H;
      return r;
    end
    if (since_manual < QuietMs) return r;
    if (t.motion) begin
      was_seen = det_seen;
      det_cnt  = (det_cnt == DetWrap) ? '0 : det_cnt + 4'd1;
      det_seen = 1'b1;
      t_motion = t.now_ms;
      if (light_state == LightOff && was_seen) begin
        mixed    = ((32'(smooth) << 2) + (32'(t.photo_sample) << 8)) / 32'd5;
        smooth   = mixed[SmoothW-1:0];
        on_lim   = 32'(bright_limit) << 8;
        half_lim = (32'(bright_limit) / 32'd3) << 8;
        if (32'(smooth) <= on_lim) begin
          if (32'(smooth) < half_lim) r.light_command = CMD_ON_50;
          else                        r.light_command = CMD_ON_100;
        end
      end
      if (det_cnt == 4'd1) r.status = ST_MOTION;
    end else begin
      det_cnt  = '0;
      det_seen = 1'b0;
      if (light_state != LightOff && t_motion != '0 &&
          (t.now_ms - t_motion) > cur_timeout) begin
        r.light_command = CMD_OFF;
        cur_timeout     = timeout_dflt;
      end
    end
    return r;
  endfunction

  function automatic mlc_out_t controller_step(input mlc_in_t t);
    mlc_out_t r;
    r.status        = ST_IDLE;
    r.light_command = CMD_NONE;
    if (t.kind == KIND_REPORT) note_light_report(t);
    else r = evaluate_poll(t);
    return r;
  endfunction

  // Channel monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mlc_out_t want;
    if (!rst_ni) begin
      clear_state();
      pending_results.delete();
      error_total   = 0;
      checked_total = 0;
      action_total  = 0;
    end else begin
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_TIMEOUT) begin
          timeout_dflt = cfg_data_i;
          cur_timeout  = cfg_data_i;
        end else if (cfg_index_i == CFG_MAX_BRIGHT) begin
          bright_limit = cfg_data_i[PhotoW-1:0];
        end
      end
      // result transaction
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result status %0d command %0d with nothing expected",
                                    out_data_i.status, out_data_i.light_command));
        end else begin
          want = pending_results.pop_front();
          checked_total++;
          if (want.status != ST_IDLE || want.light_command != CMD_NONE) action_total++;
          if (out_data_i.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d", checked_total,
                                      out_data_i.status, want.status));
          if (out_data_i.light_command !== want.light_command)
            report_mismatch($sformatf("result %0d command %0d, expected %0d", checked_total,
                                      out_data_i.light_command, want.light_command));
        end
      end
      // input transaction
      if (in_valid_i && !in_stall_i) pending_results.push_back(controller_step(in_data_i));
    end
    errors_o  <= error_total;
    pending_o <= pending_results.size();
    checked_o <= checked_total;
    actions_o <= action_total;
  end

endmodule

[bench/motion_light_controller_tb.sv]
// Testbench top for the motion light controller: clock, reset, stimulus with
// random idling on both channels, register phases, watchdog and verdict.
// Depends on mlc_pkg, motion_light_controller and mlc_checker.
module motion_light_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlc_pkg::*;

  localparam int unsigned       NumPhases     = 8;
  localparam int unsigned       PhaseItems    = 228;
  localparam int unsigned       DrainCycles   = 8;
  localparam int unsigned       WatchdogLimit = 2000;
  localparam logic [LightW-1:0] LightOff      = 2'd0;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  mlc_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  mlc_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int errors;
  int pending;
  int checked;
  int actions;

  logic [TimeW-1:0]  clock_ms;
  logic [TimeW-1:0]  timeout_now;
  logic [PhotoW-1:0] bright_now;
  int                sent;
  int                directed_items;
  int                idle_cycles = 0;
  bit                calm;

  motion_light_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  mlc_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked),
    .actions_o   (actions)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("Watchdog expired after %0d idle cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Wait cycles before a transaction; none during calm stretches
  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
  endfunction

  // Result side stalls
  initial begin : receiver
    int hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait();
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input mlc_in_t item);
    int gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    clock_ms = item.now_ms;
    sent++;
  endtask

  task automatic send_poll(input logic [TimeW-1:0] at, input logic mot,
                           input logic [PhotoW-1:0] photo);
    mlc_in_t item;
    item.kind           = KIND_POLL;
    item.now_ms         = at;
    item.motion         = mot;
    item.photo_sample   = photo;
    item.reported_light = LightW'($urandom_range(0, 3));
    item.by_controller  = 1'($urandom_range(0, 1));
    send_item(item);
  endtask

  task automatic send_report(input logic [TimeW-1:0] at, input logic [LightW-1:0] level,
                             input logic manual);
    mlc_in_t item;
    item.kind           = KIND_REPORT;
    item.now_ms         = at;
    item.motion         = 1'($urandom_range(0, 1));
    item.photo_sample   = PhotoW'($urandom_range(0, 1023));
    item.reported_light = level;
    item.by_controller  = manual;
    send_item(item);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and let every result come back before touching registers
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [PhotoW-1:0] photo_pick();
    if ($urandom_range(0, 2) == 0) return PhotoW'($urandom_range(0, 1023));
    return PhotoW'($urandom_range(0, bright_now));
  endfunction

  function automatic logic [TimeW-1:0] step_ms();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5)  return $urandom_range(0, 200);
    if (r < 10) return $urandom_range(200, 6000);
    if (r < 13) return $urandom_range(5000, 60000);
    if (r < 15) return $urandom_range(60000, 4000000);
    return $urandom_range(4000000, 90000000);
  endfunction

  // Steps that land around the active timeout
  function automatic logic [TimeW-1:0] timeout_step();
    case ($urandom_range(0, 5))
      0:       return timeout_now;
      1:       return timeout_now + 32'd1;
      2:       return HourMs;
      3:       return HourMs + 32'd1;
      4:       return $urandom_range(100, 5000);
      default: return step_ms();
    endcase
  endfunction

  // Steps that land around the end of a disable period
  function automatic logic [TimeW-1:0] disable_step();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(500, 10000);
      1:       return HourMs - $urandom_range(0, 20000);
      2:       return SixHoursMs - $urandom_range(0, 20000);
      3:       return DayMs - $urandom_range(0, 20000);
      default: return $urandom_range(0, 30000);
    endcase
  endfunction

  // Consecutive detections, an on report in most runs, then motion stopping
  task automatic motion_run();
    repeat ($urandom_range(2, 8))
      send_poll(clock_ms + $urandom_range(50, 1500), 1'b1, photo_pick());
    if ($urandom_range(0, 3) != 0)
      send_report(clock_ms + $urandom_range(10, 500), LightW'($urandom_range(1, 3)), 1'b0);
    repeat ($urandom_range(0, 3))
      send_poll(clock_ms + $urandom_range(50, 1500), 1'b1, photo_pick());
    repeat ($urandom_range(1, 4))
      send_poll(clock_ms + timeout_step(), 1'b0, PhotoW'($urandom_range(0, 1023)));
    if ($urandom_range(0, 1) == 0)
      send_report(clock_ms + $urandom_range(10, 500), LightOff, 1'b0);
  endtask

  // Manual on/off pairs, mostly quick enough to escalate, then polls
  task automatic manual_escalation();
    repeat ($urandom_range(1, 5)) begin
      send_report(clock_ms + $urandom_range(100, 2000), LightW'($urandom_range(1, 3)), 1'b1);
      send_report(clock_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(2000, 7000)
                                                          : $urandom_range(100, 2400)),
                  LightOff, 1'b1);
    end
    repeat ($urandom_range(2, 5))
      send_poll(clock_ms + disable_step(), 1'($urandom_range(0, 1)), photo_pick());
  endtask

  // Manual on stretches the timeout, probed by quiet and motionless polls
  task automatic manual_on_probe();
    send_report(clock_ms + $urandom_range(100, 6000), LightW'($urandom_range(1, 3)), 1'b1);
    send_poll(clock_ms + $urandom_range(0, 6000), 1'($urandom_range(0, 1)), photo_pick());
    repeat ($urandom_range(1, 4))
      send_poll(clock_ms + timeout_step(), $urandom_range(0, 3) == 0, photo_pick());
  endtask

  task automatic random_polls();
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 5) == 0)
        send_report(clock_ms + step_ms(), LightW'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
      else
        send_poll(clock_ms + step_ms(), 1'($urandom_range(0, 1)), photo_pick());
    end
  endtask

  // Unrelated values everywhere, time jumps included
  task automatic noise_burst();
    mlc_in_t item;
    repeat ($urandom_range(1, 4)) begin
      item.kind           = 1'($urandom_range(0, 1));
      item.now_ms         = $urandom;
      item.motion         = 1'($urandom_range(0, 1));
      item.photo_sample   = PhotoW'($urandom_range(0, 1023));
      item.reported_light = LightW'($urandom_range(0, 3));
      item.by_controller  = 1'($urandom_range(0, 1));
      send_item(item);
    end
  endtask

  initial begin : stimulus
    logic [TimeW-1:0]  t_cfg;
    logic [PhotoW-1:0] b_cfg;
    int                target;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TIMEOUT;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    calm        = 1'b0;
    clock_ms    = '0;
    timeout_now = TimeoutReset;
    bright_now  = MaxBrightReset;
    sent        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset register values
    send_poll(32'd0, 1'b1, 10'd0);           // quiet right after reset
    send_poll(32'd4999, 1'b1, 10'd1023);
    send_poll(32'd5000, 1'b1, 10'd0);        // first detection
    send_poll(32'd5100, 1'b1, 10'd0);        // dark: on at half
    send_poll(32'd5200, 1'b1, 10'd1023);     // bright: no command
    send_report(32'd5300, 2'd2, 1'b0);
    send_report(32'd5400, 2'd2, 1'b0);       // same state again
    send_poll(32'd5500, 1'b0, 10'd512);
    send_poll(32'd40201, 1'b0, 10'd0);       // one past timeout: off
    send_report(32'd40300, LightOff, 1'b1);
    send_report(32'd41500, 2'd3, 1'b1);
    send_report(32'd42000, LightOff, 1'b1);  // quick second off: 1 h
    send_poll(32'd43000, 1'b1, 10'd0);
    send_report(32'd43500, 2'd1, 1'b1);
    send_report(32'd44000, LightOff, 1'b1);  // 6 h
    send_poll(32'd44200, 1'b0, 10'd0);
    send_report(32'd44500, 2'd1, 1'b1);
    send_report(32'd45000, LightOff, 1'b1);  // 24 h
    send_report(32'd45500, 2'd2, 1'b1);
    send_report(32'd46000, LightOff, 1'b1);  // count saturates
    send_poll(32'd50000, 1'b1, 10'd0);
    send_poll(32'd86445999, 1'b0, 10'd0);    // last disabled ms
    send_poll(32'd86446000, 1'b0, 10'd0);
    send_report(32'd86447000, 2'd1, 1'b1);
    send_report(32'd86460000, LightOff, 1'b1); // slow off clears the disable
    send_report(32'hFFFF_E000, 2'd1, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b0, 10'd0);
    send_poll(32'd0, 1'b1, 10'd0);           // motion stamped at zero
    send_poll(32'h0010_0000, 1'b0, 10'd0);   // zero stamp blocks the off
    directed_items = sent;

    // Random phases, each with its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin t_cfg = TimeoutReset; b_cfg = MaxBrightReset; end
        1: begin t_cfg = '0; b_cfg = '1; end
        2: begin t_cfg = '1; b_cfg = '0; end
        3: begin
          t_cfg = $urandom_range(1000, 60000);
          b_cfg = PhotoW'($urandom_range(0, 1023));
        end
        4: begin t_cfg = $urandom; b_cfg = '1; end
        5: begin t_cfg = 32'd2000; b_cfg = PhotoW'($urandom_range(0, 1023)); end
        6: begin
          t_cfg = $urandom_range(0, 4000000);
          b_cfg = PhotoW'($urandom_range(50, 400));
        end
        default: begin t_cfg = TimeoutReset; b_cfg = PhotoW'($urandom_range(0, 1023)); end
      endcase
      write_reg(CFG_TIMEOUT, t_cfg);
      write_reg(CFG_MAX_BRIGHT, CfgDataW'(b_cfg));
      timeout_now = t_cfg;
      bright_now  = b_cfg;
      target = sent + PhaseItems;
      while (sent < target) begin
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: motion_run();
          7, 8, 9, 10:         manual_escalation();
          11, 12, 13:          manual_on_probe();
          14, 15, 16:          random_polls();
          17, 18:              noise_burst();
          default: begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            motion_run();
          end
        endcase
      end
    end
    calm = 1'b0;
    settle();

    $display("Sent %0d transactions (%0d directed) over %0d register settings.",
             sent, directed_items, NumPhases + 1);
    $display("Checked %0d results, %0d of them with a command or non-idle status.",
             checked, actions);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
